FILE: rtl/core/tro_pkg.sv
// Shared types, constants and helpers for the tiered rectangle overlap matcher.
// Used by tro_div, tro_scan and the top level in rtl/core; depends on nothing.
`timescale 1ns / 1ps

package tro_pkg;

  localparam int MAX_CANDIDATES = 64;
  localparam int COORD_W        = 16;
  localparam int IDX_W          = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
  localparam int CNT_W          = $clog2(MAX_CANDIDATES + 1);
  localparam int OUT_IDX_W      = 6;

  localparam int SCALE_W        = 24;
  localparam int THR_W          = 17;
  localparam int FRAC_SHIFT     = 16;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 24;

  localparam int DIFF_W         = COORD_W + 1;
  localparam int AREA_W         = 2 * COORD_W;
  localparam int INTER_W        = 2 * COORD_W;
  localparam int CAREA_W        = 2 * DIFF_W;
  localparam int THRP_W         = THR_W + AREA_W;
  localparam int DIVD_W         = INTER_W + FRAC_SHIFT;
  localparam int QUOT_W         = FRAC_SHIFT + 1;

  localparam int MUL_A_W        = AREA_W;
  localparam int MUL_B_W        = SCALE_W;
  localparam int MUL_P_W        = MUL_A_W + MUL_B_W;

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(65536);
  localparam logic [THR_W-1:0]   THR_RESET   = THR_W'(32768);

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE_X   = 2'd0,
    CFG_SCALE_Y   = 2'd1,
    CFG_THRESHOLD = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    cmd_t                       cmd;
    logic signed [COORD_W-1:0]  rect_left;
    logic signed [COORD_W-1:0]  rect_top;
    logic signed [COORD_W-1:0]  rect_right;
    logic signed [COORD_W-1:0]  rect_bottom;
    logic                       tier;
  } in_item_t;

  typedef struct packed {
    logic                  found;
    logic [OUT_IDX_W-1:0]  best_index;
    logic                  best_tier;
    logic [QUOT_W-1:0]     overlap_fraction;
    logic                  table_overflowed;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] l;
    logic signed [COORD_W-1:0] t;
    logic signed [COORD_W-1:0] r;
    logic signed [COORD_W-1:0] b;
  } rect_t;

  typedef struct packed {
    logic  tier;
    rect_t rect;
  } cand_t;

  typedef struct packed {
    logic               busy;
    logic               found;
    logic [IDX_W-1:0]   idx;
    logic               tier;
    logic [INTER_W-1:0] inter;
  } scan_stat_t;

  function automatic logic signed [DIFF_W-1:0] sdiff(input logic signed [COORD_W-1:0] a,
                                                     input logic signed [COORD_W-1:0] b);
    sdiff = DIFF_W'(a) - DIFF_W'(b);
  endfunction

  function automatic logic signed [COORD_W-1:0] smin(input logic signed [COORD_W-1:0] a,
                                                     input logic signed [COORD_W-1:0] b);
    smin = (a < b) ? a : b;
  endfunction

  function automatic logic signed [COORD_W-1:0] smax(input logic signed [COORD_W-1:0] a,
                                                     input logic signed [COORD_W-1:0] b);
    smax = (a > b) ? a : b;
  endfunction

endpackage

FILE: rtl/core/tro_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tro_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/tro_div.sv
// Restoring divider, one quotient bit per cycle, for the overlap fraction.
// Depends on tro_pkg.
`timescale 1ns / 1ps

module tro_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [tro_pkg::DIVD_W-1:0]    dividend,
  input  logic [tro_pkg::AREA_W-1:0]    divisor,
  output logic                          busy,
  output logic [tro_pkg::QUOT_W-1:0]    quotient
);

  localparam int STEP_W = $clog2(tro_pkg::QUOT_W);

  logic [tro_pkg::DIVD_W-1:0] rem_r;
  logic [tro_pkg::DIVD_W-1:0] den_r;
  logic [tro_pkg::QUOT_W-1:0] quo_r;
  logic [STEP_W-1:0]          step_r;
  logic                       busy_r;
  logic                       ge;

  // quotient is known to fit QUOT_W bits, so start at divisor << FRAC_SHIFT
  assign ge = rem_r >= den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      rem_r  <= dividend;
      den_r  <= tro_pkg::DIVD_W'(divisor) << tro_pkg::FRAC_SHIFT;
      quo_r  <= '0;
      step_r <= STEP_W'(tro_pkg::QUOT_W - 1);
      busy_r <= 1'b1;
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - den_r;
      end
      quo_r <= {quo_r[tro_pkg::QUOT_W-2:0], ge};
      den_r <= den_r >> 1;
      if (step_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        step_r <= step_r - STEP_W'(1);
      end
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

FILE: rtl/core/tro_scan.sv
// Candidate evaluation pipeline: one stored candidate per cycle against the
// query, with running best selection. Depends on tro_pkg.
`timescale 1ns / 1ps

module tro_scan (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         clear,
  input  logic                         rd_vld,
  input  logic [tro_pkg::IDX_W-1:0]    rd_idx,
  input  tro_pkg::cand_t               rd_data,
  input  tro_pkg::rect_t               qry,
  input  logic [tro_pkg::THRP_W-1:0]   thr_prod,
  output tro_pkg::scan_stat_t          stat
);

  // stage A: intersection and candidate sides
  logic                              a_vld_r;
  logic signed [tro_pkg::DIFF_W-1:0] a_iw_r, a_ih_r, a_cw_r, a_ch_r;
  logic                              a_tier_r;
  logic [tro_pkg::IDX_W-1:0]         a_idx_r;

  // stage B: areas
  logic                              b_vld_r;
  logic                              b_ok_r;
  logic [tro_pkg::INTER_W-1:0]       b_inter_r;
  logic [tro_pkg::CAREA_W-1:0]       b_area_r;
  logic                              b_tier_r;
  logic [tro_pkg::IDX_W-1:0]         b_idx_r;

  // stage C: threshold test
  logic                              c_vld_r;
  logic                              c_match_r;
  logic [tro_pkg::INTER_W-1:0]       c_inter_r;
  logic [tro_pkg::CAREA_W-1:0]       c_area_r;
  logic                              c_tier_r;
  logic [tro_pkg::IDX_W-1:0]         c_idx_r;

  // running best
  logic                              found_r;
  logic [tro_pkg::IDX_W-1:0]         best_idx_r;
  logic                              best_tier_r;
  logic [tro_pkg::INTER_W-1:0]       best_inter_r;
  logic [tro_pkg::CAREA_W-1:0]       best_area_r;

  logic signed [tro_pkg::CAREA_W-1:0] area_c;
  logic [tro_pkg::INTER_W-1:0]        inter_c;
  logic [tro_pkg::THRP_W-1:0]         inter_sh;
  logic                               better;

  always_comb begin
    area_c   = a_cw_r * a_ch_r;
    inter_c  = a_iw_r[tro_pkg::COORD_W-1:0] * a_ih_r[tro_pkg::COORD_W-1:0];
    inter_sh = tro_pkg::THRP_W'(b_inter_r) << tro_pkg::FRAC_SHIFT;
    // subslot beats element; then larger overlap, then smaller area
    better   = c_vld_r && c_match_r &&
               (!found_r || (c_tier_r && !best_tier_r) ||
                ((c_tier_r == best_tier_r) &&
                 ((c_inter_r > best_inter_r) ||
                  ((c_inter_r == best_inter_r) && (c_area_r < best_area_r)))));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      found_r <= 1'b0;
    end else begin
      a_vld_r <= rd_vld;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
      if (clear) begin
        found_r <= 1'b0;
      end else if (better) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_iw_r   <= tro_pkg::sdiff(tro_pkg::smin(qry.r, rd_data.rect.r),
                               tro_pkg::smax(qry.l, rd_data.rect.l));
    a_ih_r   <= tro_pkg::sdiff(tro_pkg::smin(qry.b, rd_data.rect.b),
                               tro_pkg::smax(qry.t, rd_data.rect.t));
    a_cw_r   <= tro_pkg::sdiff(rd_data.rect.r, rd_data.rect.l);
    a_ch_r   <= tro_pkg::sdiff(rd_data.rect.b, rd_data.rect.t);
    a_tier_r <= rd_data.tier;
    a_idx_r  <= rd_idx;

    b_ok_r    <= (a_iw_r > 0) && (a_ih_r > 0);
    b_inter_r <= inter_c;
    b_area_r  <= $unsigned(area_c);
    b_tier_r  <= a_tier_r;
    b_idx_r   <= a_idx_r;

    c_match_r <= b_ok_r && (inter_sh >= thr_prod);
    c_inter_r <= b_inter_r;
    c_area_r  <= b_area_r;
    c_tier_r  <= b_tier_r;
    c_idx_r   <= b_idx_r;

    if (better) begin
      best_idx_r   <= c_idx_r;
      best_tier_r  <= c_tier_r;
      best_inter_r <= c_inter_r;
      best_area_r  <= c_area_r;
    end
  end

  always_comb begin
    stat.busy  = a_vld_r || b_vld_r || c_vld_r;
    stat.found = found_r;
    stat.idx   = best_idx_r;
    stat.tier  = best_tier_r;
    stat.inter = best_inter_r;
  end

endmodule

FILE: rtl/core/tiered_rect_overlap_matcher.sv
// Top level of the tiered rectangle overlap matcher: sequencer, shared
// multiplier, candidate RAM, scan pipeline and divider.
// Depends on tro_pkg, tro_ram, tro_scan and tro_div.
//
// Usage:
//   Input items arrive on in_valid/in_ready with in_data; query results leave
//   on out_valid/out_ready with out_data. cfg_we/cfg_index/cfg_wdata write the
//   x/y scale and overlap threshold registers; the user must do so only while
//   the block is idle, which the block does not enforce. It works on one item
//   at a time; in_ready is high only when idle. In a load, the one shared
//   multiplier scales the four coordinates in turn, then the RAM is written.
//   A query scans every stored candidate and, when one matches, runs the
//   divider, which produces one fraction bit per cycle. The scan reads one
//   RAM entry per cycle through the evaluation pipeline (stages A, B and C,
//   then the running best).
//   A result sits in the output register until taken; while it waits, new
//   clears and loads are still accepted, but the next query's result holds
//   in its final state until the register frees up.
//   Reset empties the table, clears the overflow flag and restores the
//   register defaults; the RAM contents are not cleared.
`timescale 1ns / 1ps

module tiered_rect_overlap_matcher (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  tro_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output tro_pkg::out_item_t               out_data,
  input  logic                             cfg_we,
  input  logic [tro_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tro_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int NUM_CRD = 4;
  localparam int STEP_W  = 3;
  localparam int SQ_W    = tro_pkg::COORD_W + tro_pkg::SCALE_W - tro_pkg::FRAC_SHIFT;
  localparam logic [SQ_W-1:0] CRD_HI = SQ_W'((1 << (tro_pkg::COORD_W - 1)) - 1);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_SCALE  = 9'b000000010,
    S_WRITE  = 9'b000000100,
    S_REGION = 9'b000001000,
    S_AREA   = 9'b000010000,
    S_THRESH = 9'b000100000,
    S_SCAN   = 9'b001000000,
    S_DIV    = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t                             state_r, state_nxt;
  logic [STEP_W-1:0]                  step_r;
  logic [STEP_W-1:0]                  step_m1;
  logic [tro_pkg::CNT_W-1:0]          count_r;
  logic [tro_pkg::CNT_W-1:0]          scan_idx_r;
  logic                               ovf_r;
  logic [tro_pkg::SCALE_W-1:0]        sx_r, sy_r;
  logic [tro_pkg::THR_W-1:0]          thr_r;
  logic signed [tro_pkg::COORD_W-1:0] crd_r [NUM_CRD];
  logic signed [tro_pkg::COORD_W-1:0] sc_r  [NUM_CRD];
  logic                               ld_tier_r;
  tro_pkg::rect_t                     qry_r;
  logic [tro_pkg::AREA_W-1:0]         region_r;
  logic [tro_pkg::MUL_P_W-1:0]        mul_r;
  logic [tro_pkg::MUL_A_W-1:0]        mul_a;
  logic [tro_pkg::MUL_B_W-1:0]        mul_b;
  logic                               rd_vld_r;
  logic [tro_pkg::IDX_W-1:0]          rd_idx_r;
  logic                               out_valid_r;
  tro_pkg::out_item_t                 out_data_r;

  logic                               in_fire;
  logic                               issue;
  logic                               scan_end;
  logic                               ram_we;
  tro_pkg::cand_t                     wr_cand;
  logic [$bits(tro_pkg::cand_t)-1:0]  ram_rdata;
  tro_pkg::cand_t                     rd_cand;
  tro_pkg::scan_stat_t                stat;
  logic                               div_start;
  logic                               div_busy;
  logic [tro_pkg::QUOT_W-1:0]         div_q;
  logic signed [tro_pkg::DIFF_W-1:0]  qw_d, qh_d;
  logic [tro_pkg::COORD_W-1:0]        qw_c, qh_c;
  logic                               out_free;

  function automatic logic [tro_pkg::COORD_W-1:0] mag(input logic signed [tro_pkg::COORD_W-1:0] c);
    mag = c[tro_pkg::COORD_W-1] ? (~c + tro_pkg::COORD_W'(1)) : c;
  endfunction

  // drop the Q16 fraction, truncate toward zero, saturate to the coordinate range
  function automatic logic signed [tro_pkg::COORD_W-1:0] sat_coord(
      input logic neg, input logic [tro_pkg::MUL_P_W-1:0] p);
    logic [SQ_W-1:0]             q;
    logic [tro_pkg::COORD_W-1:0] qn;
    q  = p[tro_pkg::FRAC_SHIFT +: SQ_W];
    qn = q[tro_pkg::COORD_W-1:0];
    if (!neg) begin
      sat_coord = (q > CRD_HI) ? CRD_HI[tro_pkg::COORD_W-1:0] : qn;
    end else if (q > CRD_HI + SQ_W'(1)) begin
      sat_coord = {1'b1, {(tro_pkg::COORD_W - 1){1'b0}}};
    end else begin
      sat_coord = ~qn + tro_pkg::COORD_W'(1);
    end
  endfunction

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign step_m1  = step_r - STEP_W'(1);

  assign issue    = (state_r == S_SCAN) && (scan_idx_r < count_r);
  assign scan_end = (state_r == S_SCAN) && !issue && !rd_vld_r && !stat.busy;
  assign div_start = scan_end && stat.found;
  assign ram_we   = (state_r == S_WRITE);

  always_comb begin
    qw_d = tro_pkg::sdiff(qry_r.r, qry_r.l);
    qh_d = tro_pkg::sdiff(qry_r.b, qry_r.t);
    qw_c = (qw_d > 0) ? qw_d[tro_pkg::COORD_W-1:0] : tro_pkg::COORD_W'(1);
    qh_c = (qh_d > 0) ? qh_d[tro_pkg::COORD_W-1:0] : tro_pkg::COORD_W'(1);
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_SCALE: begin
        mul_a = tro_pkg::MUL_A_W'(mag(crd_r[step_r[1:0]]));
        mul_b = step_r[0] ? sy_r : sx_r;
      end
      S_REGION: begin
        mul_a = tro_pkg::MUL_A_W'(qw_c);
        mul_b = tro_pkg::MUL_B_W'(qh_c);
      end
      S_THRESH, S_SCAN: begin
        // held through the scan so mul_r keeps threshold * region
        mul_a = region_r;
        mul_b = tro_pkg::MUL_B_W'(thr_r);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_data.cmd)
            tro_pkg::CMD_LOAD: begin
              if (count_r < tro_pkg::CNT_W'(tro_pkg::MAX_CANDIDATES)) begin
                state_nxt = S_SCALE;
              end
            end
            tro_pkg::CMD_QUERY: state_nxt = S_REGION;
            default: ;
          endcase
        end
      end
      S_SCALE:  if (step_r == STEP_W'(NUM_CRD)) state_nxt = S_WRITE;
      S_WRITE:  state_nxt = S_IDLE;
      S_REGION: state_nxt = S_AREA;
      S_AREA:   state_nxt = S_THRESH;
      S_THRESH: state_nxt = S_SCAN;
      S_SCAN: begin
        if (scan_end) begin
          state_nxt = stat.found ? S_DIV : S_DONE;
        end
      end
      S_DIV:    if (!div_busy) state_nxt = S_DONE;
      S_DONE:   if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      count_r     <= '0;
      scan_idx_r  <= '0;
      ovf_r       <= 1'b0;
      sx_r        <= tro_pkg::SCALE_RESET;
      sy_r        <= tro_pkg::SCALE_RESET;
      thr_r       <= tro_pkg::THR_RESET;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= issue;

      if (cfg_we) begin
        case (cfg_index)
          tro_pkg::CFG_SCALE_X:   sx_r  <= cfg_wdata[tro_pkg::SCALE_W-1:0];
          tro_pkg::CFG_SCALE_Y:   sy_r  <= cfg_wdata[tro_pkg::SCALE_W-1:0];
          tro_pkg::CFG_THRESHOLD: thr_r <= cfg_wdata[tro_pkg::THR_W-1:0];
          default: ;
        endcase
      end

      if ((state_r == S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            case (in_data.cmd)
              tro_pkg::CMD_CLEAR: begin
                count_r <= '0;
                ovf_r   <= 1'b0;
              end
              tro_pkg::CMD_LOAD: begin
                if (count_r < tro_pkg::CNT_W'(tro_pkg::MAX_CANDIDATES)) begin
                  step_r <= '0;
                end else begin
                  ovf_r <= 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        S_SCALE:  step_r <= step_r + STEP_W'(1);
        S_WRITE:  count_r <= count_r + tro_pkg::CNT_W'(1);
        S_THRESH: scan_idx_r <= '0;
        S_SCAN:   if (issue) scan_idx_r <= scan_idx_r + tro_pkg::CNT_W'(1);
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    mul_r    <= mul_a * mul_b;
    rd_idx_r <= scan_idx_r[tro_pkg::IDX_W-1:0];

    if (in_fire) begin
      crd_r[0]  <= in_data.rect_left;
      crd_r[1]  <= in_data.rect_top;
      crd_r[2]  <= in_data.rect_right;
      crd_r[3]  <= in_data.rect_bottom;
      ld_tier_r <= in_data.tier;
      qry_r     <= '{l: in_data.rect_left, t: in_data.rect_top,
                     r: in_data.rect_right, b: in_data.rect_bottom};
    end

    if ((state_r == S_SCALE) && (step_r != '0)) begin
      sc_r[step_m1[1:0]] <= sat_coord(crd_r[step_m1[1:0]][tro_pkg::COORD_W-1], mul_r);
    end

    if (state_r == S_AREA) begin
      region_r <= mul_r[tro_pkg::AREA_W-1:0];
    end

    if ((state_r == S_DONE) && out_free) begin
      out_data_r.found            <= stat.found;
      out_data_r.best_index       <= stat.found ? tro_pkg::OUT_IDX_W'(stat.idx) : '0;
      out_data_r.best_tier        <= stat.found && stat.tier;
      out_data_r.overlap_fraction <= stat.found ? div_q : '0;
      out_data_r.table_overflowed <= ovf_r;
    end
  end

  always_comb begin
    wr_cand.tier   = ld_tier_r;
    wr_cand.rect.l = sc_r[0];
    wr_cand.rect.t = sc_r[1];
    wr_cand.rect.r = sc_r[2];
    wr_cand.rect.b = sc_r[3];
  end

  assign rd_cand = tro_pkg::cand_t'(ram_rdata);

  tro_ram #(
    .WIDTH ($bits(tro_pkg::cand_t)),
    .DEPTH (tro_pkg::MAX_CANDIDATES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[tro_pkg::IDX_W-1:0]),
    .wdata (wr_cand),
    .raddr (scan_idx_r[tro_pkg::IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  tro_scan u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .clear    (state_r == S_THRESH),
    .rd_vld   (rd_vld_r),
    .rd_idx   (rd_idx_r),
    .rd_data  (rd_cand),
    .qry      (qry_r),
    .thr_prod (mul_r[tro_pkg::THRP_W-1:0]),
    .stat     (stat)
  );

  tro_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (tro_pkg::DIVD_W'(stat.inter) << tro_pkg::FRAC_SHIFT),
    .divisor  (region_r),
    .busy     (div_busy),
    .quotient (div_q)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= tro_pkg::CNT_W'(tro_pkg::MAX_CANDIDATES))
    else $error("candidate count beyond capacity");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> count_r < tro_pkg::CNT_W'(tro_pkg::MAX_CANDIDATES))
    else $error("table write past capacity");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !div_busy && !stat.busy && !rd_vld_r)
    else $error("idle with scan or divide in flight");

  a_frac_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.found |->
      out_data.overlap_fraction <= tro_pkg::QUOT_W'(1 << tro_pkg::FRAC_SHIFT))
    else $error("overlap fraction above one");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |->
      out_data.best_index == '0 && !out_data.best_tier && out_data.overlap_fraction == '0)
    else $error("miss result carries nonzero fields");

endmodule
